@@ sv/u8ld_pkg.sv @@
// shared types and constants for the utf-8 line decoder
package u8ld_pkg;

    localparam int BYTE_W   = 8;
    localparam int CP_W     = 21;
    localparam int CONT_W   = 6;
    localparam int PEND_W   = 2;
    localparam int TDATA_IN_W  = 8;
    localparam int TDATA_OUT_W = 24;

    localparam logic [BYTE_W-1:0] CR_BYTE = 8'd13;

    // lead nibble classes
    localparam logic [3:0] NIB_ASCII_LO = 4'h0;
    localparam logic [3:0] NIB_ASCII_HI = 4'h7;
    localparam logic [3:0] NIB_CONT_LO  = 4'h8;
    localparam logic [3:0] NIB_CONT_HI  = 4'hB;
    localparam logic [3:0] NIB_LEAD2_LO = 4'hC;
    localparam logic [3:0] NIB_LEAD2_HI = 4'hD;
    localparam logic [3:0] NIB_LEAD3    = 4'hE;
    localparam logic [3:0] NIB_LEAD4    = 4'hF;

    localparam logic [PEND_W-1:0] PEND_NONE = 2'd0;
    localparam logic [PEND_W-1:0] PEND_ONE  = 2'd1;
    localparam logic [PEND_W-1:0] PEND_TWO  = 2'd2;
    localparam logic [PEND_W-1:0] PEND_THREE = 2'd3;

    typedef struct packed {
        logic              line_start;
        logic [BYTE_W-1:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic            valid;
        logic [CP_W-1:0] code_point;
    } result_t;

endpackage

@@ sv/u8ld_in_stage.sv @@
// input register stage of the utf-8 line decoder
module u8ld_in_stage
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               s_valid,
    output logic               s_ready,
    input  u8ld_pkg::in_item_t s_item,
    input  logic               advance,
    output logic               item_valid,
    output u8ld_pkg::in_item_t item
);
    import u8ld_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t item_reg;

    // the held item leaves whenever the decode stage advances
    assign s_ready    = !valid_reg || advance;
    assign valid_next = s_valid ? 1'b1 : (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (s_ready)
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_valid && s_ready)
        begin
            item_reg <= s_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

@@ sv/u8ld_core.sv @@
// decode state and single-pass byte decode
module u8ld_core
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               item_valid,
    input  u8ld_pkg::in_item_t item,
    input  logic               advance,
    output u8ld_pkg::result_t  result
);
    import u8ld_pkg::*;

    logic [PEND_W-1:0] pend_reg, pend_next;
    logic [CP_W-1:0]   acc_reg, acc_next;
    logic              disc_reg, disc_next;

    logic [PEND_W-1:0] pend_cur;
    logic [CP_W-1:0]   acc_cur;
    logic              disc_cur;
    logic [CP_W-1:0]   acc_shift;
    logic [PEND_W-1:0] pend_dec;
    logic [BYTE_W-1:0] b;
    logic              fire;

    assign fire = item_valid && advance;
    assign b    = item.data_byte;

    always_comb
    begin
        // a new line drops any open sequence and ends discarding
        pend_cur  = item.line_start ? PEND_NONE : pend_reg;
        acc_cur   = item.line_start ? '0 : acc_reg;
        disc_cur  = item.line_start ? 1'b0 : disc_reg;
        acc_shift = {acc_cur[CP_W-CONT_W-1:0], b[CONT_W-1:0]};
        pend_dec  = pend_cur - PEND_ONE;

        pend_next = pend_cur;
        acc_next  = acc_cur;
        disc_next = disc_cur;
        result    = '0;

        if (disc_cur)
        begin
            result.valid = 1'b0;
        end
        else if (pend_cur != PEND_NONE)
        begin
            pend_next = pend_dec;
            if (pend_dec == PEND_NONE)
            begin
                result.valid      = 1'b1;
                result.code_point = acc_shift;
                acc_next          = '0;
            end
            else
            begin
                acc_next = acc_shift;
            end
        end
        else
        begin
            unique case (b[7:4]) inside
                [NIB_ASCII_LO:NIB_ASCII_HI]:
                begin
                    if (b != CR_BYTE)
                    begin
                        result.valid      = 1'b1;
                        result.code_point = {{(CP_W-BYTE_W){1'b0}}, b};
                    end
                end
                [NIB_CONT_LO:NIB_CONT_HI]:
                begin
                    // stray continuation: drop the rest of the line
                    disc_next = 1'b1;
                    acc_next  = '0;
                end
                NIB_LEAD2_LO, NIB_LEAD2_HI:
                begin
                    acc_next  = {{(CP_W-5){1'b0}}, b[4:0]};
                    pend_next = PEND_ONE;
                end
                NIB_LEAD3:
                begin
                    acc_next  = {{(CP_W-4){1'b0}}, b[3:0]};
                    pend_next = PEND_TWO;
                end
                NIB_LEAD4:
                begin
                    acc_next  = {{(CP_W-3){1'b0}}, b[2:0]};
                    pend_next = PEND_THREE;
                end
                default:
                begin
                    disc_next = disc_cur;
                end
            endcase
        end

        if (!item_valid)
        begin
            result.valid = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= PEND_NONE;
            acc_reg  <= '0;
            disc_reg <= 1'b0;
        end
        else if (fire)
        begin
            pend_reg <= pend_next;
            acc_reg  <= acc_next;
            disc_reg <= disc_next;
        end
    end

endmodule

@@ sv/u8ld_out_stage.sv @@
// result register and output handshake
module u8ld_out_stage
(
    input  logic              clk,
    input  logic              rst_n,
    input  u8ld_pkg::result_t result,
    output logic              advance,
    output logic              m_valid,
    input  logic              m_ready,
    output logic [u8ld_pkg::CP_W-1:0] m_code_point
);
    import u8ld_pkg::*;

    logic            valid_reg;
    logic [CP_W-1:0] cp_reg;

    // register frees up when empty or when its transfer completes
    assign advance = !valid_reg || m_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= result.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && result.valid)
        begin
            cp_reg <= result.code_point;
        end
    end

    assign m_valid      = valid_reg;
    assign m_code_point = cp_reg;

endmodule

@@ sv/utf8_line_decoder.sv @@
// top level of the utf-8 line decoder
// Decodes a stream of UTF-8 bytes, one per transfer, into code points. Each byte passes an
// input register, a combinational decode against the sequence state and a result register,
// so one byte is taken every cycle while the output is not stalled. ASCII bytes give a code
// point at once (carriage return is dropped), multi-byte sequences give one when their
// last byte arrives, and a stray continuation byte in lead position silences the rest
// of the line.
// s_tuser marks the first byte of a line, which also drops any unfinished sequence.
module utf8_line_decoder
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,  // [7:0] data_byte
    input  logic        s_tuser,  // [0] line_start
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata   // [20:0] code_point, [23:21] zero
);
    import u8ld_pkg::*;

    in_item_t        s_item;
    in_item_t        item;
    logic            item_valid;
    logic            advance;
    result_t         result;
    logic [CP_W-1:0] code_point;

    assign s_item.data_byte  = s_tdata;
    assign s_item.line_start = s_tuser;

    u8ld_in_stage u_in
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_valid    (s_tvalid),
        .s_ready    (s_tready),
        .s_item     (s_item),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    u8ld_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .advance    (advance),
        .result     (result)
    );

    u8ld_out_stage u_out
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .result       (result),
        .advance      (advance),
        .m_valid      (m_tvalid),
        .m_ready      (m_tready),
        .m_code_point (code_point)
    );

    assign m_tdata = {{(TDATA_OUT_W-CP_W){1'b0}}, code_point};

endmodule

@@ sv/u8ld_checker.sv @@
// port-level checks for the utf-8 line decoder
module u8ld_port_checks
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [23:0] m_tdata
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("output changed while stalled");

    // padding above the code point stays zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[23:21] == 3'b000)
        else $error("output padding not zero");

    // input side only stalls behind a stalled output
    a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without output back-pressure");

    // a fresh result follows an input transfer that passed the input and result registers
    a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(s_tvalid && s_tready, 2))
        else $error("result without a matching input transfer");

endmodule

bind utf8_line_decoder u8ld_port_checks u_chk
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

@@ tb/sv/u8ld_checker.sv @@
// checker for the utf-8 line decoder: predicts code points from input transfers and compares
`timescale 1ns / 100ps

module u8ld_checker
    import u8ld_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tuser,   // [0] line_start
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,   // [20:0] code_point, [23:21] zero
    output int          fail_count,
    output int          outstanding,
    output int          checked
);

    logic [PEND_W-1:0] cont_left;
    logic [CP_W-1:0]   cp_acc;
    logic              drop_line;
    logic [CP_W-1:0]   cp_expected_q[$];

    // advance the decode state by one byte and queue any completed code point
    task automatic decode_byte(input logic [BYTE_W-1:0] b, input logic new_line);
        if (new_line)
        begin
            drop_line = 1'b0;
            cont_left = PEND_NONE;
            cp_acc    = '0;
        end
        if (drop_line)
            return;
        if (cont_left != PEND_NONE)
        begin
            // continuation bytes are taken as they come, top bits ignored
            cp_acc    = {cp_acc[CP_W-CONT_W-1:0], b[CONT_W-1:0]};
            cont_left = cont_left - 1'b1;
            if (cont_left == PEND_NONE)
            begin
                cp_expected_q = {cp_expected_q, cp_acc};
                cp_acc = '0;
            end
        end
        else if (!b[BYTE_W-1])
        begin
            if (b != CR_BYTE)
                cp_expected_q = {cp_expected_q, CP_W'(b)};
        end
        else if (b[BYTE_W-1:4] == NIB_LEAD4)
        begin
            cp_acc    = CP_W'(b[2:0]);
            cont_left = PEND_THREE;
        end
        else if (b[BYTE_W-1:4] == NIB_LEAD3)
        begin
            cp_acc    = CP_W'(b[3:0]);
            cont_left = PEND_TWO;
        end
        else if (b[BYTE_W-1:4] >= NIB_LEAD2_LO)
        begin
            cp_acc    = CP_W'(b[4:0]);
            cont_left = PEND_ONE;
        end
        else
        begin
            // stray continuation in lead position silences the line
            drop_line = 1'b1;
            cp_acc    = '0;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        logic [CP_W-1:0] cp_exp;
        if (!rst_n)
        begin
            cont_left   = PEND_NONE;
            cp_acc      = '0;
            drop_line   = 1'b0;
            cp_expected_q.delete();
            fail_count  <= 0;
            outstanding <= 0;
            checked     <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                decode_byte(s_tdata[BYTE_W-1:0], s_tuser);
            if (m_tvalid && m_tready)
            begin
                checked <= checked + 1;
                if (cp_expected_q.size() == 0)
                begin
                    $error("unexpected code point %06h", m_tdata[CP_W-1:0]);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    cp_exp = cp_expected_q.pop_front();
                    if (m_tdata[CP_W-1:0] !== cp_exp)
                    begin
                        $error("code_point: expected %06h, got %06h", cp_exp,
                               m_tdata[CP_W-1:0]);
                        fail_count <= fail_count + 1;
                    end
                    else if (m_tdata[TDATA_OUT_W-1:CP_W] !== '0)
                    begin
                        $error("tdata padding: expected 0, got %0h",
                               m_tdata[TDATA_OUT_W-1:CP_W]);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            outstanding <= cp_expected_q.size();
        end
    end

endmodule

@@ tb/sv/tb.sv @@
// testbench top for the utf-8 line decoder: clock, reset, byte stimulus and verdict
`timescale 1ns / 100ps

module tb;
    import u8ld_pkg::*;

    localparam int RANDOM_BYTES = 1150;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;   // [7:0] data_byte
    logic        s_tuser = 1'b0; // [0] line_start
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;        // [20:0] code_point, [23:21] zero

    int fail_count;
    int outstanding;
    int checked;

    int   burst_left = 0;
    int   bytes_sent = 0;
    int   lines_sent = 0;
    int   rx_cycle = 0;
    logic next_start = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    utf8_line_decoder dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    u8ld_checker chk
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .fail_count  (fail_count),
        .outstanding (outstanding),
        .checked     (checked)
    );

    // receiver: cycles through free-flowing, random, periodic and heavy stalling
    always @(negedge clk)
    begin
        rx_cycle <= rx_cycle + 1;
        case ((rx_cycle / 97) % 4)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 9) < 7);
            2: m_tready <= ((rx_cycle % 7) < 4);
            default: m_tready <= ($urandom_range(0, 3) == 0);
        endcase
    end

    // one byte transfer; the sender runs in bursts with random gaps between them
    task automatic send_byte(input logic [7:0] b);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            repeat (gap)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
                s_tdata  <= 8'($urandom);
                s_tuser  <= 1'($urandom);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tuser  <= next_start;
        next_start = 1'b0;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        bytes_sent++;
    endtask

    function automatic logic [7:0] cont_byte();
        // mostly proper continuation bytes, sometimes anything at all
        if ($urandom_range(0, 9) == 0)
            return 8'($urandom);
        return {2'b10, 6'($urandom)};
    endfunction

    function automatic logic [7:0] lead_byte(input int n_bytes);
        case (n_bytes)
            2:       return {3'b110, 5'($urandom)};
            3:       return {4'b1110, 4'($urandom)};
            default: return {4'b1111, 4'($urandom)};
        endcase
    endfunction

    task automatic send_line();
        int n_chars;
        int kind;
        int n_bytes;
        n_chars = $urandom_range(1, 12);
        next_start = 1'b1;
        lines_sent++;
        for (int i = 0; i < n_chars; i++)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 35)
                send_byte(8'($urandom_range(0, 127)));
            else if (kind < 40)
                send_byte(CR_BYTE);
            else if (kind < 88)
            begin
                n_bytes = (kind < 58) ? 2 : (kind < 74) ? 3 : 4;
                send_byte(lead_byte(n_bytes));
                for (int k = 1; k < n_bytes; k++)
                    send_byte(cont_byte());
            end
            else if (kind < 92)
                send_byte({2'b10, 6'($urandom)});
            else
                send_byte(8'($urandom));
        end
        // an unfinished sequence left hanging at the end of the line
        if ($urandom_range(0, 9) == 0)
        begin
            n_bytes = $urandom_range(2, 4);
            send_byte(lead_byte(n_bytes));
            for (int k = $urandom_range(2, n_bytes); k < n_bytes; k++)
                send_byte(cont_byte());
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed: field extremes, each lead class, dropped cr, stray and truncated cases
        next_start = 1'b1;
        send_byte(8'h00);
        send_byte(8'h7F);
        send_byte(CR_BYTE);
        send_byte(8'hC0);
        send_byte(8'h80);
        send_byte(8'hDF);
        send_byte(8'hFF);
        send_byte(8'hE0);
        send_byte(CR_BYTE);
        send_byte(8'h41);
        send_byte(8'hFF);
        send_byte(8'hBF);
        send_byte(8'hBF);
        send_byte(8'hBF);
        send_byte(8'hF0);
        send_byte(8'h80);
        next_start = 1'b1;
        send_byte(8'h80);
        send_byte(8'h41);
        next_start = 1'b1;
        send_byte(8'hE5);
        next_start = 1'b1;
        send_byte(8'h41);
        send_byte(8'hBF);
        send_byte(8'h42);
        lines_sent += 4;

        // random: mostly well-formed lines, with some raw noise lines
        while (bytes_sent < RANDOM_BYTES + 22)
        begin
            if ($urandom_range(0, 19) == 0)
            begin
                repeat ($urandom_range(1, 10))
                begin
                    next_start = 1'($urandom);
                    send_byte(8'($urandom));
                end
            end
            else
                send_line();
        end

        @(negedge clk);
        s_tvalid <= 1'b0;
        wait (outstanding == 0);
        repeat (8) @(posedge clk);

        $display("sent %0d bytes over about %0d lines, checked %0d code points",
                 bytes_sent, lines_sent, checked);
        if (fail_count == 0 && outstanding == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("timeout with %0d code points still awaited", outstanding);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

@@ utf8_line_decoder.f @@
sv/u8ld_pkg.sv
sv/u8ld_in_stage.sv
sv/u8ld_core.sv
sv/u8ld_out_stage.sv
sv/utf8_line_decoder.sv
sv/u8ld_checker.sv
tb/sv/u8ld_checker.sv
tb/sv/tb.sv
